>>> rtl/mnemonic_opcode_hash_table_core_assert.svh
// ----------------------------------------------------------------------------
// mnemonic opcode hash table assertion macros
// concurrent checks sampled on clk_i, muted while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef MNEMONIC_OPCODE_HASH_TABLE_CORE_ASSERT_SVH
`define MNEMONIC_OPCODE_HASH_TABLE_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MOHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MOHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/moht_pkg.sv
// ----------------------------------------------------------------------------
// moht_pkg
// shared constants, status codes and types of the mnemonic opcode table
// ----------------------------------------------------------------------------
package moht_pkg;

  // table geometry
  localparam int WAYS      = 8;
  localparam int MAX_CHARS = 8;
  localparam int NBUCKETS  = 20;

  // field widths
  localparam int CHAR_W = 8;
  localparam int NAME_W = 64;
  localparam int LEN_W  = 4;
  localparam int OP_W   = 8;
  localparam int BKT_W  = 5;
  localparam int STAT_W = 2;
  localparam int FILL_W = $clog2(WAYS + 1);

  // legal character range
  localparam int CHAR_LO = 65;
  localparam int CHAR_HI = 90;

  // hash arithmetic
  localparam int MOD_BASE = 1000;
  localparam int SUM_W    = $clog2(MAX_CHARS * CHAR_HI + 1);
  localparam int SQ_W     = 2 * SUM_W;
  localparam int RECIP_K  = SQ_W + 10;
  localparam longint unsigned RECIP_M =
    ((longint'(1) << RECIP_K) + MOD_BASE - 1) / MOD_BASE;
  localparam int RM_W     = $clog2(RECIP_M + 1);
  localparam int P2_W     = SQ_W + RM_W;
  localparam int Q_W      = SQ_W - 9;
  localparam int R_W      = $clog2(MOD_BASE);
  localparam int DF_W     = Q_W + R_W + 1;
  localparam int DIV10_M  = 205;
  localparam int DIV10_SH = 11;
  localparam int P10_W    = R_W + 8;
  localparam int DIG_W    = 7;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [NAME_W-1:0] name;
    logic [LEN_W-1:0]  len;
    logic [OP_W-1:0]   opcode;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [BKT_W-1:0] bucket;
  } hash_res_t;

endpackage

>>> rtl/moht_hash.sv
// ----------------------------------------------------------------------------
// moht_hash
// four-stage bucket hash: char check and sum-square, reciprocal quotient,
// remainder mod 1000, tens/hundreds digits mod 20
// ----------------------------------------------------------------------------
module moht_hash (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [moht_pkg::NAME_W-1:0]  chars_i,
  input  logic [moht_pkg::LEN_W-1:0]   len_i,
  output moht_pkg::hash_res_t          res_o
);
  import moht_pkg::*;

  logic [SUM_W-1:0]  sum;
  logic              bad;
  logic [CHAR_W-1:0] ch;

  logic              v1_q, v2_q, v3_q, v4_q;
  logic              bad1_q, bad2_q, bad3_q, bad4_q;
  logic [SQ_W-1:0]   sq_q, sq2_q;
  logic [Q_W-1:0]    quo_q;
  logic [R_W-1:0]    rem_q;
  logic [BKT_W-1:0]  bkt_q;

  logic [P2_W-1:0]   prod2;
  logic [DF_W-1:0]   tq, diff;
  logic [R_W-1:0]    rem_d;
  logic [P10_W-1:0]  prod10;
  logic [DIG_W-1:0]  dig;

  // char range check and sum, bytes past the length are already zero
  always_comb begin
    sum = '0;
    bad = 1'b0;
    ch  = '0;
    for (int i = 0; i < MAX_CHARS; i++) begin
      ch  = chars_i[CHAR_W*i +: CHAR_W];
      sum = sum + SUM_W'(ch);
      if ((LEN_W'(i) < len_i) &&
          ((ch < CHAR_W'(CHAR_LO)) || (ch > CHAR_W'(CHAR_HI)))) begin
        bad = 1'b1;
      end
    end
  end

  // quotient estimate is exact or one too high
  assign prod2 = P2_W'(sq_q) * P2_W'(RECIP_M);
  assign tq    = DF_W'(quo_q) * DF_W'(MOD_BASE);
  assign diff  = DF_W'(sq2_q) - tq;
  assign rem_d = diff[DF_W-1] ? R_W'(diff + DF_W'(MOD_BASE)) : R_W'(diff);

  // divide by ten, then fold the two digits into 0..19
  assign prod10 = P10_W'(rem_q) * P10_W'(DIV10_M);

  always_comb begin
    dig = prod10[DIV10_SH +: DIG_W];
    if (dig >= DIG_W'(4 * NBUCKETS)) begin
      dig = dig - DIG_W'(4 * NBUCKETS);
    end
    if (dig >= DIG_W'(2 * NBUCKETS)) begin
      dig = dig - DIG_W'(2 * NBUCKETS);
    end
    if (dig >= DIG_W'(NBUCKETS)) begin
      dig = dig - DIG_W'(NBUCKETS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q   <= SQ_W'(sum) * SQ_W'(sum);
    bad1_q <= bad;
    quo_q  <= prod2[RECIP_K +: Q_W];
    sq2_q  <= sq_q;
    bad2_q <= bad1_q;
    rem_q  <= rem_d;
    bad3_q <= bad2_q;
    bkt_q  <= BKT_W'(dig);
    bad4_q <= bad3_q;
  end

  assign res_o.valid  = v4_q;
  assign res_o.bad    = bad4_q;
  assign res_o.bucket = bkt_q;

endmodule

>>> rtl/mnemonic_opcode_hash_table_core.sv
// ----------------------------------------------------------------------------
// flow: a taken request beat passes the start register, the 4-stage hash
//   pipe, the registered bucket row read and the read-modify-write turn,
//   which waits for a free output register; one request is in flight at a time
// reset: rst_ni clears the bucket fill counters and control at once; there
//   is no clearing pass, entries past a bucket's fill count are never read
// ----------------------------------------------------------------------------
// mnemonic_opcode_hash_table_core
// opcode table keyed by uppercase mnemonics, 20 buckets of WAYS slots each
// ----------------------------------------------------------------------------
`include "mnemonic_opcode_hash_table_core_assert.svh"

module mnemonic_opcode_hash_table_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [moht_pkg::NAME_W-1:0]   mnemonic_chars_i,
  input  logic [moht_pkg::LEN_W-1:0]    mnemonic_length_i,
  input  logic [moht_pkg::OP_W-1:0]     opcode_in_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          found_o,
  output logic [moht_pkg::OP_W-1:0]     opcode_out_o,
  output logic [moht_pkg::BKT_W-1:0]    bucket_index_o,
  output logic [moht_pkg::STAT_W-1:0]   status_o
);
  import moht_pkg::*;

  // sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HASH = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0]        state_q, state_d;
  logic              start_q;

  // captured request, chars already masked past the saturated length
  logic              req_insert_q;
  logic [NAME_W-1:0] req_chars_q;
  logic [LEN_W-1:0]  req_len_q;
  logic [OP_W-1:0]   req_op_q;
  logic [LEN_W-1:0]  len_sat;
  logic [NAME_W-1:0] chars_m;
  logic              in_fire;

  hash_res_t         hash_res;
  logic [BKT_W-1:0]  bkt_q;
  logic              bad_q;

  // bucket store: one row of WAYS entries per bucket
  row_t              tbl_mem [NBUCKETS];
  row_t              rd_row_q;
  row_t              wr_row;
  logic              mem_re;
  logic              mem_we;

  logic [FILL_W-1:0] fill_q [NBUCKETS];
  logic [FILL_W-1:0] fill_cur;
  logic              full;

  // lookup / result path
  logic              hit;
  logic [OP_W-1:0]   hit_op;
  logic              resp_load;
  logic              found_d;
  logic [OP_W-1:0]   opcode_d;
  logic [BKT_W-1:0]  bucket_d;
  logic [STAT_W-1:0] status_d;

  logic              out_valid_q;
  logic              found_q;
  logic [OP_W-1:0]   opcode_q;
  logic [BKT_W-1:0]  bucket_q;
  logic [STAT_W-1:0] status_q;

  // one request in flight, output register decoupled from the next request
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // overlong lengths saturate, bytes past the length become zero
  always_comb begin
    len_sat = mnemonic_length_i;
    if (mnemonic_length_i > LEN_W'(MAX_CHARS)) begin
      len_sat = LEN_W'(MAX_CHARS);
    end
    chars_m = '0;
    for (int i = 0; i < NAME_W / CHAR_W; i++) begin
      if (LEN_W'(i) < len_sat) begin
        chars_m[CHAR_W*i +: CHAR_W] = mnemonic_chars_i[CHAR_W*i +: CHAR_W];
      end
    end
  end

  moht_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .chars_i (req_chars_q),
    .len_i   (req_len_q),
    .res_o   (hash_res)
  );

  // sequencer: wait for the hash, read the bucket row, then respond
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_res.valid) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (resp_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_insert_q <= req_type_i;
      req_chars_q  <= chars_m;
      req_len_q    <= len_sat;
      req_op_q     <= opcode_in_i;
    end
    if (mem_re) begin
      bkt_q <= hash_res.bucket;
      bad_q <= hash_res.bad;
    end
  end

  // row read when the hash lands, row write back on a successful insert
  assign mem_re = (state_q == S_HASH) && hash_res.valid;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem[bkt_q] <= wr_row;
    end
    if (mem_re) begin
      rd_row_q <= tbl_mem[hash_res.bucket];
    end
  end

  assign fill_cur = fill_q[bkt_q];
  assign full     = (fill_cur >= FILL_W'(WAYS));

  // compare every way of the row, the lowest live slot wins
  always_comb begin
    hit    = 1'b0;
    hit_op = '0;
    for (int k = WAYS - 1; k >= 0; k--) begin
      if ((FILL_W'(k) < fill_cur) &&
          (rd_row_q[k].len == req_len_q) &&
          (rd_row_q[k].name == req_chars_q)) begin
        hit    = 1'b1;
        hit_op = rd_row_q[k].opcode;
      end
    end
  end

  // append the new entry at the fill position
  always_comb begin
    wr_row = rd_row_q;
    for (int k = 0; k < WAYS; k++) begin
      if (FILL_W'(k) == fill_cur) begin
        wr_row[k].name   = req_chars_q;
        wr_row[k].len    = req_len_q;
        wr_row[k].opcode = req_op_q;
      end
    end
  end

  // result is built once the output register is free
  assign resp_load = (state_q == S_RESP) && (!out_valid_q || out_ready_i);
  assign mem_we    = resp_load && !bad_q && req_insert_q && !full;

  always_comb begin
    found_d  = 1'b0;
    opcode_d = '0;
    bucket_d = bkt_q;
    status_d = ST_OK;
    if (bad_q) begin
      bucket_d = '0;
      status_d = ST_BAD_CHAR;
    end else if (req_insert_q) begin
      if (full) begin
        status_d = ST_FULL;
      end
    end else begin
      found_d  = hit;
      opcode_d = hit_op;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NBUCKETS; b++) begin
        fill_q[b] <= '0;
      end
    end else if (mem_we) begin
      fill_q[bkt_q] <= fill_cur + FILL_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_load) begin
      found_q  <= found_d;
      opcode_q <= opcode_d;
      bucket_q <= bucket_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign opcode_out_o   = opcode_q;
  assign bucket_index_o = bucket_q;
  assign status_o       = status_q;

  // checks
  `MOHT_ASSERT_NOW(a_hash_only_when_waiting, hash_res.valid, state_q == S_HASH,
    "hash result arrived outside the hash wait")
  `MOHT_ASSERT_NEXT(a_accept_starts_hash, in_fire, start_q && (state_q == S_HASH),
    "accepted beat did not start the hash")
  `MOHT_ASSERT_NOW(a_fill_bounded, state_q == S_RESP, fill_cur <= FILL_W'(WAYS),
    "bucket fill count above slot count")
  `MOHT_ASSERT_NOW(a_found_on_lookup, resp_load && found_d, !req_insert_q && !bad_q,
    "found flag on an insert or rejected key")
  `MOHT_ASSERT_NOW(a_reject_zeroed, out_valid_o && (status_o == ST_BAD_CHAR),
    (bucket_index_o == '0) && !found_o && (opcode_out_o == '0),
    "rejected key result not zeroed")

endmodule
